[design/ptb_pkg.sv]
package ptb_pkg;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_IDLE    = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SWEEP = 1'b1
    } state_t;

endpackage

[design/periodic_timer_bank.sv]
// create, start and stop: one result in the cycle after the transfer; busy stays low,
// so one of these items can be taken every cycle
// tick: busy until the sweep is done; the shared decrementer visits one
// allocated slot per cycle, behind the registered read of the count and period memories
// results are strobed on done for one cycle each; the receiver cannot stall
// reset clears control state, running bits and the allocation count; memories are not cleared
module periodic_timer_bank #(
    parameter int SLOT_COUNT  = 10,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [3:0]  timer_index,
    input  logic [31:0] period_ms,
    output logic        done,
    output logic [1:0]  kind,
    output logic [3:0]  slot_id,
    output logic        bank_full,
    output logic        bad_index,
    output logic        last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    ptb_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]      alloc_reg, alloc_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [SLOT_COUNT-1:0] running_reg, running_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]      rd_slot_reg, rd_slot_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_slot_reg, pend_slot_next;

    logic                  done_reg, done_next;
    ptb_pkg::kind_t        kind_reg, kind_next;
    logic [3:0]            slot_reg, slot_next;
    logic                  full_reg, full_next;
    logic                  bad_reg, bad_next;
    logic                  last_reg, last_next;

    logic [COUNT_WIDTH-1:0] rem_mem [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] rel_mem [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] rem_q, rel_q;
    logic                   rem_we, rel_we;
    logic [IDX_W-1:0]       rem_waddr;
    logic [COUNT_WIDTH-1:0] rem_wdata;

    logic                   accept;
    logic                   scan_live;
    logic                   issue_rd;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] dec;
    logic                   expire;
    logic                   sweep_done;
    logic [COUNT_WIDTH-1:0] period_w;
    ptb_pkg::action_t       act;

    assign act        = ptb_pkg::action_t'(action);
    assign busy       = (state_reg != ptb_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign period_w   = COUNT_WIDTH'(period_ms);
    assign rd_addr    = scan_reg[IDX_W-1:0];
    assign scan_live  = (scan_reg < alloc_reg);
    assign issue_rd   = scan_live && running_reg[rd_addr];
    assign dec        = rem_q - COUNT_WIDTH'(1);
    assign expire     = rd_valid_reg && (dec == '0);
    assign sweep_done = (state_reg == ptb_pkg::ST_SWEEP) && !scan_live && !rd_valid_reg;

    // count and period memories, read data registered
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rem_q <= rem_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rel_we)
        begin
            rel_mem[alloc_reg[IDX_W-1:0]] <= period_w;
        end
        rel_q <= rel_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (accept && act == ptb_pkg::ACT_TICK)
                begin
                    state_next = ptb_pkg::ST_SWEEP;
                end
            end
            ptb_pkg::ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        alloc_next      = alloc_reg;
        scan_next       = scan_reg;
        running_next    = running_reg;
        rd_valid_next   = 1'b0;
        rd_slot_next    = rd_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        done_next       = 1'b0;
        kind_next       = ptb_pkg::KIND_IDLE;
        slot_next       = '0;
        full_next       = 1'b0;
        bad_next        = 1'b0;
        last_next       = 1'b0;
        rem_we          = 1'b0;
        rel_we          = 1'b0;
        rem_waddr       = alloc_reg[IDX_W-1:0];
        rem_wdata       = period_w;

        unique case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        ptb_pkg::ACT_CREATE:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            kind_next = ptb_pkg::KIND_CREATED;
                            if (int'(alloc_reg) < SLOT_COUNT)
                            begin
                                rem_we     = 1'b1;
                                rel_we     = 1'b1;
                                slot_next  = 4'(alloc_reg);
                                alloc_next = alloc_reg + CNT_W'(1);
                                for (int i = 0; i < SLOT_COUNT; i++)
                                begin
                                    if (int'(alloc_reg) == i)
                                    begin
                                        running_next[i] = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        ptb_pkg::ACT_START, ptb_pkg::ACT_STOP:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            kind_next = ptb_pkg::KIND_ACK;
                            if (int'(timer_index) >= SLOT_COUNT)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                for (int i = 0; i < SLOT_COUNT; i++)
                                begin
                                    if (int'(timer_index) == i)
                                    begin
                                        running_next[i] = (act == ptb_pkg::ACT_START);
                                    end
                                end
                            end
                        end
                        ptb_pkg::ACT_TICK:
                        begin
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            scan_next = '0;
                        end
                    endcase
                end
            end
            ptb_pkg::ST_SWEEP:
            begin
                // read slot scan while slot rd_slot is written back
                rd_valid_next = issue_rd;
                rd_slot_next  = rd_addr;
                if (scan_live)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    rem_we    = 1'b1;
                    rem_waddr = rd_slot_reg;
                    rem_wdata = expire ? rel_q : dec;
                end
                // hold back each expiry until the next one shows whether it is the last
                if (expire)
                begin
                    pend_valid_next = 1'b1;
                    pend_slot_next  = rd_slot_reg;
                    if (pend_valid_reg)
                    begin
                        done_next = 1'b1;
                        kind_next = ptb_pkg::KIND_EXPIRED;
                        slot_next = 4'(pend_slot_reg);
                    end
                end
                if (sweep_done)
                begin
                    done_next       = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        kind_next = ptb_pkg::KIND_EXPIRED;
                        slot_next = 4'(pend_slot_reg);
                    end
                end
            end
            default:
            begin
                rd_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptb_pkg::ST_IDLE;
            alloc_reg      <= '0;
            scan_reg       <= '0;
            running_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alloc_reg      <= alloc_next;
            scan_reg       <= scan_next;
            running_reg    <= running_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg   <= rd_slot_next;
        pend_slot_reg <= pend_slot_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        full_reg      <= full_next;
        bad_reg       <= bad_next;
        last_reg      <= last_next;
    end

    assign done      = done_reg;
    assign kind      = kind_reg;
    assign slot_id   = slot_reg;
    assign bank_full = full_reg;
    assign bad_index = bad_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(alloc_reg) <= SLOT_COUNT)
        else $error("allocation count beyond bank size");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action != ptb_pkg::ACT_TICK |=> done && last_reg && !busy)
        else $error("create, start or stop did not give one final result");

    a_nonlast_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_reg |-> kind_reg == ptb_pkg::KIND_EXPIRED && busy)
        else $error("non-final result that is not an expiry during a sweep");

    a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> busy && $past(busy))
        else $error("memory read outside a sweep");
`endif

endmodule
